// File: rtl/deq_pkg.sv
// Shared types and codes for the double-ended queue.
// Used by deq_cell, deq_result and double_ended_queue; depends on nothing.
package deq_pkg;

	localparam int WORD_W   = 32;
	localparam int MODE_W   = 3;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// Operation codes carried in the input tuser.
	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd4;

	// Result status codes carried in the output tuser.
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	typedef logic signed [WORD_W-1:0] word_t;

	// Qualified operation broadcast to every cell of the chain.
	typedef struct packed {
		logic ins_front;
		logic ins_back;
		logic rem_front;
		logic rem_back;
	} deq_op_t;

	// One result word as held in the output register.
	typedef struct packed {
		logic          is_empty;
		logic [COUNT_W-1:0] entry_count;
		word_t         back_value;
		word_t         front_value;
		logic [STATUS_W-1:0] status;
	} deq_res_t;

endpackage

// File: rtl/deq_cell.sv
// One storage cell of the queue chain: a word and its occupied flag.
// Depends on deq_pkg for the word and operation types.
module deq_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  deq_pkg::deq_op_t op,
	input  deq_pkg::word_t  push_value,
	input  deq_pkg::word_t  left_data,
	input  logic            left_vld,
	input  deq_pkg::word_t  right_data,
	input  logic            right_vld,
	output deq_pkg::word_t  data,
	output logic            vld
);
	import deq_pkg::*;

	word_t data_q, data_d;
	logic  vld_q, vld_d;

	// Next state from the neighbors: the chain shifts toward the back on a
	// front push and toward the front on a front pop; back operations touch
	// only the cell at the occupied boundary.
	always_comb begin
		data_d = data_q;
		vld_d  = vld_q;
		if (op.ins_front) begin
			data_d = left_data;
			vld_d  = left_vld;
		end else if (op.ins_back) begin
			if (!vld_q && left_vld) begin
				data_d = push_value;
				vld_d  = 1'b1;
			end
		end else if (op.rem_front) begin
			data_d = right_data;
			vld_d  = right_vld;
		end else if (op.rem_back) begin
			if (vld_q && !right_vld) begin
				vld_d = 1'b0;
			end
		end
	end

	// The stored word needs no reset; it is only read while occupied.
	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_d;
		end
	end

	assign data = data_q;
	assign vld  = vld_q;

endmodule

// File: rtl/deq_result.sv
// Output stage: picks front and back words from the cell chain and holds
// the result word until the sink takes it. Depends on deq_pkg.
module deq_result #(
	parameter int DEPTH = 16,
	parameter int CNT_W = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  logic [deq_pkg::STATUS_W-1:0] status,
	input  deq_pkg::word_t       cell_data [DEPTH],
	input  logic [DEPTH-1:0]     cell_vld,
	input  logic [CNT_W-1:0]     cnt,
	input  logic                 out_ready,
	output logic                 slot_free,
	output logic                 out_valid,
	output deq_pkg::deq_res_t    res
);
	import deq_pkg::*;

	deq_res_t res_q, res_d;
	logic     valid_q;
	word_t    back_sel;
	logic [DEPTH-1:0] tail;

	// The back entry is the one occupied cell whose right neighbor is free.
	assign tail = cell_vld & ~(cell_vld >> 1);

	always_comb begin
		back_sel = '0;
		for (int i = 0; i < DEPTH; i++) begin
			back_sel = back_sel | (cell_data[i] & {WORD_W{tail[i]}});
		end
	end

	// Assemble the result from the chain state after the operation.
	always_comb begin
		res_d.status      = status;
		res_d.front_value = cell_vld[0] ? cell_data[0] : '1;
		res_d.back_value  = cell_vld[0] ? back_sel : '1;
		res_d.entry_count = COUNT_W'(cnt);
		res_d.is_empty    = ~cell_vld[0];
	end

	assign slot_free = !valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (load && slot_free) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= load;
		end
	end

	assign out_valid = valid_q;
	assign res       = res_q;

	// An empty result always reports a zero count and both ends as all ones.
	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && res_q.is_empty |->
		res_q.entry_count == '0 && res_q.front_value == '1 && res_q.back_value == '1)
		else $error("empty result carries stale fields");

	// A dropped push is only reported when every cell is occupied.
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		load && slot_free && status == STATUS_FULL |-> cell_vld[DEPTH-1])
		else $error("full status while the chain has room");

	// Exactly one tail cell whenever the queue holds anything.
	a_one_tail: assert property (@(posedge clk) disable iff (!arst_n)
		cell_vld[0] |-> $onehot(tail))
		else $error("occupied cells are not contiguous");

endmodule

// File: rtl/double_ended_queue.sv
// Double-ended queue of signed words kept as a chain of DEPTH cells.
// Each taken word updates the cell chain; its result word is then registered
// in the output stage. Throughput: one word per cycle while the sink keeps up;
// the output register decouples the sink.
// Reset (arst_n, asynchronous) empties the queue and clears the output valid.
// Depends on deq_pkg, deq_cell and deq_result.
module double_ended_queue #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] push_value
	input  logic [2:0]  s_axis_tuser,  // [2:0] mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // [31:0] front_value, [63:32] back_value,
	                                   // [68:64] entry_count, [69] is_empty, rest zero
	output logic [1:0]  m_axis_tuser   // [1:0] status
);
	import deq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	word_t            cell_data [DEPTH];
	logic [DEPTH-1:0] cell_vld;
	logic [CNT_W-1:0] cnt_q;
	logic             pend_q;
	logic [STATUS_W-1:0] stat_s1;
	logic             accept, full, empty, slot_free;
	logic [STATUS_W-1:0] stat_d;
	deq_op_t          op;
	deq_res_t         res;
	word_t            push_value;

	assign push_value = word_t'(s_axis_tdata);
	assign full  = cell_vld[DEPTH-1];
	assign empty = ~cell_vld[0];

	// A new word is taken unless a finished result still waits for the slot.
	assign s_axis_tready = !pend_q || slot_free;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Decode the mode into a qualified operation and its status.
	always_comb begin
		op     = '0;
		stat_d = STATUS_OK;
		case (s_axis_tuser)
			MODE_PUSH_FRONT: begin
				if (full) stat_d = STATUS_FULL;
				else      op.ins_front = accept;
			end
			MODE_PUSH_BACK: begin
				if (full) stat_d = STATUS_FULL;
				else      op.ins_back = accept;
			end
			MODE_POP_FRONT: begin
				if (empty) stat_d = STATUS_EMPTY;
				else       op.rem_front = accept;
			end
			MODE_POP_BACK: begin
				if (empty) stat_d = STATUS_EMPTY;
				else       op.rem_back = accept;
			end
			default: begin
				stat_d = STATUS_OK;
			end
		endcase
	end

	// The chain of cells; the ends see a fresh word on the left and an
	// always-free cell on the right.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		word_t ld, rd;
		logic  lv, rv;
		if (i == 0) begin : g_first
			assign ld = push_value;
			assign lv = 1'b1;
		end else begin : g_mid_l
			assign ld = cell_data[i-1];
			assign lv = cell_vld[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign rd = '0;
			assign rv = 1'b0;
		end else begin : g_mid_r
			assign rd = cell_data[i+1];
			assign rv = cell_vld[i+1];
		end
		deq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.push_value (push_value),
			.left_data  (ld),
			.left_vld   (lv),
			.right_data (rd),
			.right_vld  (rv),
			.data       (cell_data[i]),
			.vld        (cell_vld[i])
		);
	end

	// Entry count follows the qualified operation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (op.ins_front || op.ins_back) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (op.rem_front || op.rem_back) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// The status is registered beside the updated chain and held until the result loads.
	always_ff @(posedge clk) begin
		if (accept) begin
			stat_s1 <= stat_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (accept) begin
			pend_q <= 1'b1;
		end else if (slot_free) begin
			pend_q <= 1'b0;
		end
	end

	deq_result #(
		.DEPTH (DEPTH),
		.CNT_W (CNT_W)
	) u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (pend_q),
		.status    (stat_s1),
		.cell_data (cell_data),
		.cell_vld  (cell_vld),
		.cnt       (cnt_q),
		.out_ready (m_axis_tready),
		.slot_free (slot_free),
		.out_valid (m_axis_tvalid),
		.res       (res)
	);

	assign m_axis_tuser = res.status;
	assign m_axis_tdata = {2'b00, res.is_empty, res.entry_count,
	                       res.back_value, res.front_value};

	// The count register always matches the occupied cells.
	a_cnt_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_vld) == int'(cnt_q))
		else $error("entry count out of step with the cell chain");

	// Occupied cells form one run starting at the front cell.
	a_contig: assert property (@(posedge clk) disable iff (!arst_n)
		((cell_vld >> 1) & ~cell_vld) == '0)
		else $error("hole in the occupied cells");

	// A pending result never stays behind a newly taken word.
	a_pend: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> pend_q)
		else $error("taken word left no pending result");

endmodule
